### rtl/apid_pkg.sv
// Shared types and constants for the arm position PID controller.
// Holds register indexes, reset values and request codes; no dependencies.
`default_nettype none

package apid_pkg;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgGainP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainI     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainD     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpLimit   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNudgeStep = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPresetExc = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPresetSw  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgPresetSc  = 3'd7;

  // Field widths fixed by the interface
  localparam int GainW   = 32;
  localparam int CountW  = 11;   // limit and preset magnitudes
  localparam int StepW   = 8;
  localparam int SpW     = 12;   // signed setpoint
  localparam int DriveW  = 16;   // signed Q1.15
  localparam int ReqW    = 3;
  localparam int NudgeW  = 2;
  localparam int DriveShift = 17;

  localparam logic [GainW-1:0]  GainPRst     = 32'd12884902;
  localparam logic [GainW-1:0]  GainIRst     = 32'd43;
  localparam logic [GainW-1:0]  GainDRst     = 32'd4295;
  localparam logic [CountW-1:0] SpLimitRst   = 11'd700;
  localparam logic [StepW-1:0]  NudgeStepRst = 8'd12;
  localparam logic [CountW-1:0] PresetExcRst = 11'd650;
  localparam logic [CountW-1:0] PresetSwRst  = 11'd300;
  localparam logic [CountW-1:0] PresetScRst  = 11'd100;

  // Preset request codes
  localparam logic [ReqW-1:0] ReqNone   = 3'd0;
  localparam logic [ReqW-1:0] ReqMiddle = 3'd1;
  localparam logic [ReqW-1:0] ReqExc    = 3'd2;
  localparam logic [ReqW-1:0] ReqSwitch = 3'd3;
  localparam logic [ReqW-1:0] ReqScale  = 3'd4;

  // Nudge codes
  localparam logic [NudgeW-1:0] NudgeNone = 2'd0;
  localparam logic [NudgeW-1:0] NudgeUp   = 2'd1;
  localparam logic [NudgeW-1:0] NudgeDown = 2'd2;

  localparam logic signed [DriveW-1:0] DriveMax = 16'sd32767;
  localparam logic signed [DriveW-1:0] DriveMin = -16'sd32767;

endpackage

`default_nettype wire

### rtl/arm_position_pid_with_setpoints.sv
// Top level of the arm position PID controller with setpoint presets.
// Depends on apid_pkg for register indexes, reset values and request codes.
//
// One word in is one control period: the preset and nudge update the held
// setpoint, which is clamped to the limit, and a PID on setpoint minus
// position yields a saturated Q1.15 drive. The block takes a word every
// cycle while in_stall_o is low; the four stages are the input register,
// the state update (setpoint, saturating integral, previous error), the
// gain multipliers, and the final sum with saturation. Stages advance
// independently, so a stalled result only blocks the pipe once every stage
// holds a word. The user must write configuration only while no word is in
// flight; the block itself does not enforce this.
`default_nettype none

module arm_position_pid_with_setpoints #(
  parameter int POSITION_WIDTH = 16,
  parameter int SUM_WIDTH      = 40
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             cfg_we_i,
  input  wire logic [apid_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [apid_pkg::CfgDataW-1:0]    cfg_data_i,

  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [POSITION_WIDTH-1:0] position_i,
  input  wire logic [apid_pkg::ReqW-1:0]        preset_request_i,
  input  wire logic                             forward_i,
  input  wire logic [apid_pkg::NudgeW-1:0]      nudge_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [apid_pkg::DriveW-1:0]    drive_o,
  output logic signed [apid_pkg::SpW-1:0]       setpoint_now_o,
  output logic signed [((POSITION_WIDTH > apid_pkg::SpW) ? POSITION_WIDTH
                        : apid_pkg::SpW):0]     error_now_o
);

  import apid_pkg::*;

  localparam int PosMaxW = (POSITION_WIDTH > SpW) ? POSITION_WIDTH : SpW;
  localparam int ErrW    = PosMaxW + 1;
  localparam int DiffW   = ErrW + 1;
  localparam int AddW    = ((SUM_WIDTH > ErrW) ? SUM_WIDTH : ErrW) + 1;
  localparam int SumXW   = 64;
  localparam int HalfW   = SumXW / 2;
  localparam int PeW     = ErrW + GainW + 1;
  localparam int PdW     = DiffW + GainW + 1;
  localparam int PlW     = HalfW + GainW;
  localparam int PhW     = HalfW + GainW + 1;
  localparam int AccW    = SumXW + GainW + 4;
  localparam int ShW     = AccW - DriveShift;
  localparam int SpxW    = SpW + 1;

  localparam logic signed [AddW-1:0] SumMax =
    {{(AddW - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
  localparam logic signed [AddW-1:0] SumMin = ~SumMax;

  // Configuration registers
  logic [GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [CountW-1:0] sp_limit_q, preset_exc_q, preset_sw_q, preset_sc_q;
  logic [StepW-1:0]  nudge_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= GainPRst;
      gain_i_q     <= GainIRst;
      gain_d_q     <= GainDRst;
      sp_limit_q   <= SpLimitRst;
      nudge_step_q <= NudgeStepRst;
      preset_exc_q <= PresetExcRst;
      preset_sw_q  <= PresetSwRst;
      preset_sc_q  <= PresetScRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgGainP:     gain_p_q     <= cfg_data_i[GainW-1:0];
        CfgGainI:     gain_i_q     <= cfg_data_i[GainW-1:0];
        CfgGainD:     gain_d_q     <= cfg_data_i[GainW-1:0];
        CfgSpLimit:   sp_limit_q   <= cfg_data_i[CountW-1:0];
        CfgNudgeStep: nudge_step_q <= cfg_data_i[StepW-1:0];
        CfgPresetExc: preset_exc_q <= cfg_data_i[CountW-1:0];
        CfgPresetSw:  preset_sw_q  <= cfg_data_i[CountW-1:0];
        CfgPresetSc:  preset_sc_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its
  // successor loads.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  logic adv12;
  assign adv12 = v1_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: input register
  logic signed [POSITION_WIDTH-1:0] pos1_q;
  logic [ReqW-1:0]                  req1_q;
  logic                             fwd1_q;
  logic [NudgeW-1:0]                nudge1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      pos1_q   <= position_i;
      req1_q   <= preset_request_i;
      fwd1_q   <= forward_i;
      nudge1_q <= nudge_i;
    end
  end

  // Stage 2: setpoint update, error, saturating integral, difference
  logic signed [SpW-1:0]       setpoint_q;
  logic signed [SUM_WIDTH-1:0] error_sum_q;
  logic signed [ErrW-1:0]      prev_err_q;

  logic signed [SpxW-1:0]      sp_base, sp_nudged, sp_lim, sp_clamped;
  logic signed [SpxW-1:0]      preset_mag, step_x;
  logic                        preset_hit;
  logic signed [ErrW-1:0]      err_d;
  logic signed [AddW-1:0]      sum_raw;
  logic signed [SUM_WIDTH-1:0] sum_d;
  logic signed [DiffW-1:0]     diff_d;

  always_comb begin
    preset_hit = 1'b1;
    preset_mag = '0;
    unique case (req1_q)
      ReqMiddle: preset_mag = '0;
      ReqExc:    preset_mag = SpxW'($signed({1'b0, preset_exc_q}));
      ReqSwitch: preset_mag = SpxW'($signed({1'b0, preset_sw_q}));
      ReqScale:  preset_mag = SpxW'($signed({1'b0, preset_sc_q}));
      default:   preset_hit = 1'b0;
    endcase

    if (preset_hit) begin
      sp_base = fwd1_q ? preset_mag : -preset_mag;
    end else begin
      sp_base = SpxW'(setpoint_q);
    end

    step_x = SpxW'($signed({1'b0, nudge_step_q}));
    unique case (nudge1_q)
      NudgeUp:   sp_nudged = sp_base + step_x;
      NudgeDown: sp_nudged = sp_base - step_x;
      default:   sp_nudged = sp_base;
    endcase

    // Clamp every period, with or without a nudge
    sp_lim = SpxW'($signed({1'b0, sp_limit_q}));
    if (sp_nudged > sp_lim) begin
      sp_clamped = sp_lim;
    end else if (sp_nudged < -sp_lim) begin
      sp_clamped = -sp_lim;
    end else begin
      sp_clamped = sp_nudged;
    end

    err_d = ErrW'(sp_clamped) - ErrW'(pos1_q);

    sum_raw = AddW'(error_sum_q) + AddW'(err_d);
    if (sum_raw > SumMax) begin
      sum_d = SUM_WIDTH'(SumMax);
    end else if (sum_raw < SumMin) begin
      sum_d = SUM_WIDTH'(SumMin);
    end else begin
      sum_d = sum_raw[SUM_WIDTH-1:0];
    end

    diff_d = DiffW'(prev_err_q) - DiffW'(err_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= '0;
      error_sum_q <= '0;
      prev_err_q  <= '0;
    end else if (adv12) begin
      setpoint_q  <= sp_clamped[SpW-1:0];
      error_sum_q <= sum_d;
      prev_err_q  <= err_d;
    end
  end

  logic signed [SpW-1:0]       sp2_q;
  logic signed [ErrW-1:0]      err2_q;
  logic signed [SUM_WIDTH-1:0] sum2_q;
  logic signed [DiffW-1:0]     diff2_q;

  always_ff @(posedge clk_i) begin
    if (adv12) begin
      sp2_q   <= sp_clamped[SpW-1:0];
      err2_q  <= err_d;
      sum2_q  <= sum_d;
      diff2_q <= diff_d;
    end
  end

  // Stage 3: gain products; the integral is split into two 32-bit halves
  logic signed [SumXW-1:0] sum_x;
  logic [HalfW-1:0]        sum_lo;
  logic signed [HalfW-1:0] sum_hi;
  logic signed [PeW-1:0]   pe_d;
  logic signed [PdW-1:0]   pd_d;
  logic [PlW-1:0]          pl_d;
  logic signed [PhW-1:0]   ph_d;

  assign sum_x  = SumXW'(sum2_q);
  assign sum_lo = sum_x[HalfW-1:0];
  assign sum_hi = sum_x[SumXW-1:HalfW];
  assign pe_d   = $signed({1'b0, gain_p_q}) * err2_q;
  assign pd_d   = $signed({1'b0, gain_d_q}) * diff2_q;
  assign pl_d   = gain_i_q * sum_lo;
  assign ph_d   = $signed({1'b0, gain_i_q}) * sum_hi;

  logic signed [SpW-1:0]  sp3_q;
  logic signed [ErrW-1:0] err3_q;
  logic signed [PeW-1:0]  pe3_q;
  logic signed [PdW-1:0]  pd3_q;
  logic [PlW-1:0]         pl3_q;
  logic signed [PhW-1:0]  ph3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sp3_q  <= sp2_q;
      err3_q <= err2_q;
      pe3_q  <= pe_d;
      pd3_q  <= pd_d;
      pl3_q  <= pl_d;
      ph3_q  <= ph_d;
    end
  end

  // Stage 4: exact sum, floor shift to Q1.15, saturate
  logic signed [AccW-1:0]   acc;
  logic signed [ShW-1:0]    acc_sh;
  logic signed [DriveW-1:0] drive_d;

  always_comb begin
    acc = AccW'(pe3_q) + AccW'(pd3_q) + AccW'($signed({1'b0, pl3_q}))
        + (AccW'(ph3_q) <<< HalfW);
    acc_sh = acc[AccW-1:DriveShift];
    if (acc_sh > ShW'(DriveMax)) begin
      drive_d = DriveMax;
    end else if (acc_sh < ShW'(DriveMin)) begin
      drive_d = DriveMin;
    end else begin
      drive_d = acc_sh[DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      drive_o        <= drive_d;
      setpoint_now_o <= sp3_q;
      error_now_o    <= err3_q;
    end
  end

  assign out_valid_o = v4_q;

  // Assertions
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with an empty stage");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv12 |=> ($stable(setpoint_q) && $stable(error_sum_q) && $stable(prev_err_q)))
    else $error("controller state changed without a word advancing");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o != {1'b1, {(DriveW-1){1'b0}}}))
    else $error("drive outside plus or minus one");

  a_sp_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((setpoint_now_o <= $signed({2'b00, sp_limit_q}))
                  && (setpoint_now_o >= -$signed({2'b00, sp_limit_q}))))
    else $error("setpoint beyond limit");

endmodule

`default_nettype wire
